FILE: src/gtt_pkg.sv
`default_nettype none

package gtt_pkg;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_HOLD = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int IN_KEY_W   = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINGER     = 2'd2;

  localparam logic [TIME_W-1:0] QUARANTINE_RST = 32'd599;
  localparam logic [TIME_W-1:0] LINGER_RST     = 32'd432000;

endpackage

`default_nettype wire

FILE: src/gtt_ram.sv
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module gtt_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/greylist_triplet_table_unit.sv
`default_nettype none

// Greylisting triplet table. Raise start with a request while busy is low; the
// request is taken at that edge. A disabled unit, a free-pass request or a
// request without a recipient is answered on the next cycle and busy stays
// low. Any other request scans the table one slot per cycle through the
// registered-read table RAM: a hit ends the scan at that slot, a miss writes
// the key into the first free slot before the result, or the key is dropped
// when the table is full. busy is high during the scan. The result is on out_*
// for exactly one cycle with out_valid high; the receiver cannot stall it, so
// capture it on that cycle.
// After reset the unit sweeps every RAM slot once to clear the valid flags,
// with busy high; configuration writes are taken at any time (cfg_ready is
// always high) but should be issued only while the unit is idle.

module greylist_triplet_table_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [gtt_pkg::IN_KEY_W-1:0]     in_triplet_key,
  input  wire logic [gtt_pkg::TIME_W-1:0]       in_now_seconds,
  input  wire logic                             in_freepass_granted,
  input  wire logic                             in_has_recipient,
  // result channel
  output logic                                  out_valid,
  output logic      [1:0]                       out_verdict,
  output logic      [gtt_pkg::TIME_W-1:0]       out_wait_seconds,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int TW      = gtt_pkg::TIME_W;
  // entry layout: {valid, first_seen, key}
  localparam int ENTRY_W = 1 + TW + KEY_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic          enabled_r;
  logic [TW-1:0] quar_r;
  logic [TW-1:0] linger_r;

  // latched request
  logic [KEY_BITS-1:0] key_r;
  logic [TW-1:0]       now_r;

  // scan bookkeeping; cnt_r MSB flags "all reads issued"
  logic [IDX_W:0]   cnt_r;
  logic             ev_valid_r;
  logic [IDX_W-1:0] ev_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [TW-1:0]    age_r;

  // result registers
  logic          out_valid_r;
  logic [1:0]    out_verdict_r;
  logic [TW-1:0] out_wait_r;

  // RAM ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  gtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fields of the entry under evaluation
  logic                e_valid;
  logic [TW-1:0]       e_time;
  logic [KEY_BITS-1:0] e_key;
  logic [TW-1:0]       e_age;
  logic                e_hit;
  logic                e_stale;
  logic                e_free;

  assign e_valid = ram_rdata[ENTRY_W-1];
  assign e_time  = ram_rdata[KEY_BITS +: TW];
  assign e_key   = ram_rdata[KEY_BITS-1:0];
  assign e_age   = now_r - e_time;
  assign e_hit   = e_valid && (e_key == key_r);
  assign e_stale = e_valid && !e_hit && (e_age > linger_r);
  assign e_free  = !e_valid || e_stale;

  logic accept;
  logic bypass;
  assign accept = start && !busy;
  // requests answered without touching the table
  assign bypass = !enabled_r || in_freepass_granted || !in_has_recipient;

  // RAM access steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_r;
    ram_wdata = '0;
    ram_raddr = cnt_r[IDX_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IDX_W-1:0];
      end
      ST_SCAN: begin
        // purge a stale entry the scan passed over
        ram_we = ev_valid_r && e_stale;
      end
      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = free_idx_r;
        ram_wdata = {1'b1, now_r, key_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      quar_r    <= gtt_pkg::QUARANTINE_RST;
      linger_r  <= gtt_pkg::LINGER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtt_pkg::CFG_ENABLED:    enabled_r <= cfg_data[0];
        gtt_pkg::CFG_QUARANTINE: quar_r    <= cfg_data;
        gtt_pkg::CFG_LINGER:     linger_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      ev_valid_r   <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[IDX_W-1:0] == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            key_r        <= in_triplet_key[KEY_BITS-1:0];
            now_r        <= in_now_seconds;
            cnt_r        <= '0;
            ev_valid_r   <= 1'b0;
            free_found_r <= 1'b0;
            if (bypass) begin
              out_valid_r <= 1'b1;
              out_wait_r  <= '0;
              if (enabled_r && !in_freepass_granted) begin
                out_verdict_r <= gtt_pkg::VERDICT_FAIL;
              end else begin
                out_verdict_r <= gtt_pkg::VERDICT_PASS;
              end
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // read slot cnt_r, evaluate slot ev_idx_r read last cycle
          if (!cnt_r[IDX_W]) begin
            cnt_r <= cnt_r + 1'b1;
          end
          ev_valid_r <= !cnt_r[IDX_W];
          ev_idx_r   <= cnt_r[IDX_W-1:0];
          if (ev_valid_r) begin
            if (e_hit) begin
              age_r   <= e_age;
              state_r <= ST_DONE;
            end else begin
              if (e_free && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= ev_idx_r;
              end
              if (ev_idx_r == LAST_IDX) begin
                // miss: age zero, insert if a slot is free, else drop
                age_r <= '0;
                if (free_found_r || e_free) begin
                  state_r <= ST_INSERT;
                end else begin
                  state_r <= ST_DONE;
                end
              end
            end
          end
        end
        ST_INSERT: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          if (age_r < quar_r) begin
            out_verdict_r <= gtt_pkg::VERDICT_HOLD;
            out_wait_r    <= quar_r - age_r;
          end else begin
            out_verdict_r <= gtt_pkg::VERDICT_PASS;
            out_wait_r    <= '0;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_wait_seconds = out_wait_r;

endmodule

`default_nettype wire

FILE: src/gtt_checker.sv
`default_nettype none

module gtt_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_freepass_granted,
  input wire logic        in_has_recipient,
  input wire logic        out_valid,
  input wire logic [1:0]  out_verdict,
  input wire logic [31:0] out_wait_seconds
);

  // only a hold carries a wait
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != gtt_pkg::VERDICT_HOLD) |-> out_wait_seconds == '0)
    else $error("nonzero wait without hold");

  // a hold always has time left
  a_hold_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == gtt_pkg::VERDICT_HOLD) |-> out_wait_seconds != '0)
    else $error("hold with zero wait");

  // free pass answered next cycle with pass
  a_freepass: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_freepass_granted
      |=> out_valid && (out_verdict == gtt_pkg::VERDICT_PASS))
    else $error("free pass not passed");

  // missing recipient answered next cycle, fail or pass when disabled
  a_no_rcpt: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_freepass_granted && !in_has_recipient
      |=> out_valid && ((out_verdict == gtt_pkg::VERDICT_FAIL) ||
                        (out_verdict == gtt_pkg::VERDICT_PASS)))
    else $error("no-recipient request misanswered");

endmodule

bind greylist_triplet_table_unit gtt_props u_gtt_props (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_freepass_granted (in_freepass_granted),
  .in_has_recipient    (in_has_recipient),
  .out_valid           (out_valid),
  .out_verdict         (out_verdict),
  .out_wait_seconds    (out_wait_seconds)
);

`default_nettype wire

FILE: test/gtt_checker.sv
module gtt_checker #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [gtt_pkg::IN_KEY_W-1:0]   in_triplet_key,
  input  wire logic [gtt_pkg::TIME_W-1:0]     in_now_seconds,
  input  wire logic                           in_freepass_granted,
  input  wire logic                           in_has_recipient,
  input  wire logic                           out_valid,
  input  wire logic [1:0]                     out_verdict,
  input  wire logic [gtt_pkg::TIME_W-1:0]     out_wait_seconds,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [gtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gtt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    gtt_pkg::verdict_t          verdict;
    logic [gtt_pkg::TIME_W-1:0] wait_s;
  } reply_t;

  reply_t                       expected_replies[$];

  // shadow of the triplet table and the registers
  logic [gtt_pkg::IN_KEY_W-1:0] tbl_key   [TABLE_DEPTH];
  logic [gtt_pkg::TIME_W-1:0]   tbl_stamp [TABLE_DEPTH];
  logic                         tbl_live  [TABLE_DEPTH];
  logic                         gl_on;
  logic [gtt_pkg::TIME_W-1:0]   hold_s;
  logic [gtt_pkg::TIME_W-1:0]   purge_s;

  function automatic reply_t grade_triplet(input logic [gtt_pkg::IN_KEY_W-1:0] key,
                                           input logic [gtt_pkg::TIME_W-1:0] now,
                                           input logic fp, input logic rcpt);
    reply_t                       r;
    logic [gtt_pkg::IN_KEY_W-1:0] k;
    logic [gtt_pkg::TIME_W-1:0]   age;
    logic [gtt_pkg::TIME_W-1:0]   a;
    bit                           hit;
    int                           slot;
    r.verdict = gtt_pkg::VERDICT_PASS;
    r.wait_s  = '0;
    if (!gl_on || fp) return r;
    if (!rcpt) begin
      r.verdict = gtt_pkg::VERDICT_FAIL;
      return r;
    end
    k   = key & (~64'd0 >> (64 - KEY_BITS));
    age = '0;
    hit = 0;
    // scan in slot order; stale non-matching entries get purged on the way
    for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
      if (tbl_live[i]) begin
        a = now - tbl_stamp[i];
        if (tbl_key[i] == k) begin
          age = a;
          hit = 1;
        end else if (a > purge_s) begin
          tbl_live[i] = 1'b0;
        end
      end
    end
    if (!hit) begin
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (!tbl_live[i] && slot < 0) slot = i;
      // full table: key dropped
      if (slot >= 0) begin
        tbl_live[slot]  = 1'b1;
        tbl_key[slot]   = k;
        tbl_stamp[slot] = now;
      end
      age = '0;
    end
    if (age < hold_s) begin
      r.verdict = gtt_pkg::VERDICT_HOLD;
      r.wait_s  = hold_s - age;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_live[i] = 1'b0;
      gl_on   = 1'b1;
      hold_s  = gtt_pkg::QUARANTINE_RST;
      purge_s = gtt_pkg::LINGER_RST;
      expected_replies.delete();
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result, verdict %0d wait %0d", $time,
                   out_verdict, out_wait_seconds);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (out_verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d, got %0d", $time,
                     want.verdict, out_verdict);
            mismatches++;
          end
          if (out_wait_seconds !== want.wait_s) begin
            $display("%0t: wait_seconds expected %0d, got %0d", $time,
                     want.wait_s, out_wait_seconds);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtt_pkg::CFG_ENABLED:    gl_on   = cfg_data[0];
          gtt_pkg::CFG_QUARANTINE: hold_s  = cfg_data;
          gtt_pkg::CFG_LINGER:     purge_s = cfg_data;
          default:                 ;
        endcase
      end
      if (start && !busy)
        expected_replies.push_back(grade_triplet(in_triplet_key, in_now_seconds,
                                                 in_freepass_granted,
                                                 in_has_recipient));
    end
    outstanding = expected_replies.size();
  end

endmodule

FILE: test/greylist_triplet_table_unit_tb.sv
module greylist_triplet_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 64;
  localparam int POOL_SIZE   = 24;

  // index past the last register; the block must ignore it
  localparam logic [gtt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [gtt_pkg::IN_KEY_W-1:0]   in_triplet_key;
  logic [gtt_pkg::TIME_W-1:0]     in_now_seconds;
  logic                           in_freepass_granted;
  logic                           in_has_recipient;
  logic                           out_valid;
  logic [1:0]                     out_verdict;
  logic [gtt_pkg::TIME_W-1:0]     out_wait_seconds;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [gtt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gtt_pkg::CFG_DATA_W-1:0] cfg_data;

  int                             mismatches;
  int                             outstanding;

  // stimulus-side copies of the register values, only to shape time steps
  logic [gtt_pkg::TIME_W-1:0]     cur_q;
  logic [gtt_pkg::TIME_W-1:0]     cur_l;
  logic [gtt_pkg::TIME_W-1:0]     clock_s;
  logic [gtt_pkg::IN_KEY_W-1:0]   key_pool [POOL_SIZE];
  int                             sender_idle;

  greylist_triplet_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_triplet_key     (in_triplet_key),
    .in_now_seconds     (in_now_seconds),
    .in_freepass_granted(in_freepass_granted),
    .in_has_recipient   (in_has_recipient),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_wait_seconds   (out_wait_seconds),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  gtt_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_triplet_key     (in_triplet_key),
    .in_now_seconds     (in_now_seconds),
    .in_freepass_granted(in_freepass_granted),
    .in_has_recipient   (in_has_recipient),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_wait_seconds   (out_wait_seconds),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Drop start and wait until the block is idle with no reply owed.
  // Every request yields exactly one reply, so an empty reply queue plus
  // busy low means nothing is still in flight.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  // One register write; valid is left high so back-to-back writes never
  // lower and raise it in the same step.
  task automatic put_reg(input logic [gtt_pkg::CFG_IDX_W-1:0] idx,
                         input logic [gtt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes every register, plus a junk write to the unused index.
  task automatic apply_settings(input logic [gtt_pkg::CFG_DATA_W-1:0] en_word,
                                input logic [gtt_pkg::TIME_W-1:0] q_s,
                                input logic [gtt_pkg::TIME_W-1:0] l_s);
    settle();
    put_reg(gtt_pkg::CFG_ENABLED, en_word);
    put_reg(gtt_pkg::CFG_QUARANTINE, q_s);
    put_reg(gtt_pkg::CFG_LINGER, l_s);
    put_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    cur_q = q_s;
    cur_l = l_s;
  endtask

  // Issue one request. Called right after a falling edge; start stays high
  // when the next request follows with no gap.
  task automatic issue_request(input logic [gtt_pkg::IN_KEY_W-1:0] key,
                               input logic [gtt_pkg::TIME_W-1:0] now,
                               input logic fp, input logic rcpt);
    while ($urandom_range(0, 99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_triplet_key      <= key;
    in_now_seconds      <= now;
    in_freepass_granted <= fp;
    in_has_recipient    <= rcpt;
    start               <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random traffic: keys mostly recycled from a small pool so triplets come
  // back (hold, then pass), with fresh keys mixed in at fresh_pct percent.
  // Time mostly creeps forward, sometimes jumps past the linger window,
  // sometimes goes backwards or lands anywhere.
  task automatic run_phase(input int n, input int idle, input int fresh_pct);
    logic [gtt_pkg::IN_KEY_W-1:0] k;
    int unsigned                  step_max;
    int                           pick;
    sender_idle = idle;
    step_max = (cur_q > 20000) ? 20000 : cur_q / 2 + 1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < fresh_pct) begin
        k = {$urandom, $urandom};
        key_pool[pick] = k;
      end else begin
        k = key_pool[pick];
      end
      case ($urandom_range(0, 19))
        0:       clock_s = $urandom;
        1:       clock_s = clock_s - $urandom_range(1, 5000);
        2:       clock_s = clock_s + cur_l + $urandom_range(1, 50);
        3, 4, 5: ;
        default: clock_s = clock_s + $urandom_range(0, step_max);
      endcase
      issue_request(k, clock_s, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    logic [gtt_pkg::IN_KEY_W-1:0] k0, k1, k2, k3;

    // known values on every input from time zero
    rst_n               = 1'b0;
    start               = 1'b0;
    in_triplet_key      = '0;
    in_now_seconds      = '0;
    in_freepass_granted = 1'b0;
    in_has_recipient    = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = gtt_pkg::CFG_ENABLED;
    cfg_data            = '0;
    sender_idle         = 0;
    cur_q               = gtt_pkg::QUARANTINE_RST;
    cur_l               = gtt_pkg::LINGER_RST;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part -----------------------------------------------
    // settle() inside covers the clearing sweep after reset
    apply_settings(32'd1, gtt_pkg::QUARANTINE_RST, gtt_pkg::LINGER_RST);
    k0 = '0;
    k1 = '1;
    k2 = {$urandom, $urandom};
    k3 = {$urandom, $urandom};

    issue_request(k0, 32'd1000, 1'b0, 1'b1);        // miss, full wait
    issue_request(k0, 32'd1300, 1'b0, 1'b1);        // hit, partial wait
    issue_request(k0, 32'd1599, 1'b0, 1'b1);        // age equals quarantine
    issue_request(k1, 32'hFFFF_FFFF, 1'b0, 1'b1);   // all-ones key, max time
    issue_request(k1, 32'd0, 1'b0, 1'b1);           // time wraps, age one
    issue_request(k0, 32'd500, 1'b0, 1'b1);         // clock went backwards
    issue_request(k2, 32'd1000, 1'b1, 1'b1);        // free pass
    issue_request(k2, 32'd1000, 1'b0, 1'b0);        // no recipient
    issue_request(k2, 32'd1000, 1'b1, 1'b0);        // free pass wins
    issue_request(k3, 32'd433001, 1'b0, 1'b1);      // both old entries purged
    issue_request(k0, 32'd433001, 1'b0, 1'b1);      // purged key re-enters
    issue_request(k3, 32'd865001, 1'b0, 1'b1);      // age exactly linger

    // disabled, with stray upper bits in the enable word
    apply_settings(32'hFFFF_FFFE, gtt_pkg::QUARANTINE_RST, gtt_pkg::LINGER_RST);
    issue_request(k2, 32'd5, 1'b0, 1'b1);
    issue_request(k2, 32'd5, 1'b0, 1'b0);

    // zero quarantine and zero linger
    apply_settings(32'h8000_0001, 32'd0, 32'd0);
    issue_request(k2, 32'd7, 1'b0, 1'b1);           // wrapped ages purge all
    issue_request(k2, 32'd7, 1'b0, 1'b1);
    issue_request(k0, 32'd7, 1'b0, 1'b1);           // age zero is not purged

    // --- random part -------------------------------------------------
    clock_s = 32'd10000;

    // defaults, back-to-back requests
    apply_settings(32'd1, gtt_pkg::QUARANTINE_RST, gtt_pkg::LINGER_RST);
    run_phase(250, 0, 15);

    // everything passes, aggressive purge, sender mostly idle
    apply_settings(32'd1, 32'd0, 32'd0);
    run_phase(150, 81, 15);

    // nothing ever purged and mostly new keys: drives the table full
    apply_settings(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(320, 34, 85);

    // disabled block leaves the table alone
    apply_settings({31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0}, $urandom, $urandom);
    run_phase(60, 81, 15);

    // short windows so holds, passes and purges all interleave
    cur_q = $urandom_range(1, 5000);
    apply_settings(32'd1, cur_q, cur_q + $urandom_range(0, 20000));
    run_phase(200, 0, 15);

    // anything goes in the registers
    apply_settings($urandom, $urandom, $urandom);
    run_phase(100, 34, 30);

    // drain, then give a stray late result time to show up
    settle();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("greylist_triplet_table_unit_tb OK");
    end else begin
      $display("greylist_triplet_table_unit_tb NOT OK");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #12ms;
    $display("greylist_triplet_table_unit_tb NOT OK");
    $finish;
  end

endmodule
